### src/ispsc_pkg.sv
// Shared types and constants for the INI section and pair scanner.
// Used by every module and by the channel interfaces; depends on nothing.
package ispsc_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int FIELD_BITS = 16;

  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_HASH   = 8'h23;
  localparam logic [7:0] CHAR_LBRACK = 8'h5B;
  localparam logic [7:0] CHAR_RBRACK = 8'h5D;
  localparam logic [7:0] CHAR_EQ     = 8'h3D;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_CR,
    CLS_LF,
    CLS_HASH,
    CLS_LBRACK,
    CLS_RBRACK,
    CLS_EQ,
    CLS_BLANK
  } byte_class_t;

  typedef enum logic [3:0] {
    MODE_PRE,
    MODE_PRE_CMT,
    MODE_SEC,
    MODE_BODY,
    MODE_BODY_CMT,
    MODE_KEY,
    MODE_GAP,
    MODE_VAL,
    MODE_ERR
  } scan_mode_t;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_SECTION,
    EV_PAIR,
    EV_ERROR
  } event_kind_t;

  typedef struct packed {
    byte_class_t cls;
    logic        fin;
  } queue_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    case (b)
      CHAR_CR:     c = CLS_CR;
      CHAR_LF:     c = CLS_LF;
      CHAR_HASH:   c = CLS_HASH;
      CHAR_LBRACK: c = CLS_LBRACK;
      CHAR_RBRACK: c = CLS_RBRACK;
      CHAR_EQ:     c = CLS_EQ;
      CHAR_SPACE:  c = CLS_BLANK;
      CHAR_TAB:    c = CLS_BLANK;
      default:     c = CLS_OTHER;
    endcase
    return c;
  endfunction

endpackage

### src/ispsc_if.sv
// Valid/ready channel interfaces for the scanner's text input and event output.
// Depends on ispsc_pkg for the field widths.
interface ispsc_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

interface ispsc_event_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         event_kind;
  logic                               end_of_text;
  logic [ispsc_pkg::FIELD_BITS-1:0]   name_start;
  logic [ispsc_pkg::FIELD_BITS-1:0]   name_length;
  logic [ispsc_pkg::FIELD_BITS-1:0]   value_start;
  logic [ispsc_pkg::FIELD_BITS-1:0]   value_length;

  modport source (output valid, output event_kind, output end_of_text, output name_start,
                  output name_length, output value_start, output value_length,
                  input ready);
  modport sink (input valid, input event_kind, input end_of_text, input name_start,
                input name_length, input value_start, input value_length,
                output ready);
endinterface

### src/ini_section_pair_scanner.sv
// INI section and key/value scanner: takes one text byte per beat and returns
// one event beat per finished section, finished pair, error and end of text.
// The block accepts a byte every cycle while its queue is not full. A byte's event
// reaches the output through the queue: the classified byte is written to the queue
// at the accepting edge, and popped into the event output register once that is free.
// Offsets are OFFSET_BITS wide internally and wrap; event fields are 16 bits.
// Depends on ispsc_pkg, the channel interfaces, ispsc_front, ispsc_queue, ispsc_back.
module ini_section_pair_scanner #(
  parameter int OFFSET_BITS = ispsc_pkg::OFFSET_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  ispsc_text_if.sink    text_in,
  ispsc_event_if.source event_out
);
  import ispsc_pkg::*;

  queue_entry_t  push_entry;
  queue_entry_t  head;
  queue_status_t status;
  logic          push;
  logic          pop;

  ispsc_front u_front (
    .text_in (text_in),
    .status  (status),
    .push    (push),
    .entry   (push_entry)
  );

  ispsc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (status)
  );

  ispsc_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .status    (status),
    .pop       (pop),
    .event_out (event_out)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("Back end popped an empty queue.");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> !status.empty)
    else $error("Queue empty after an unmatched push.");

  a_status_sane: assert property (@(posedge clk) disable iff (rst)
    !(status.full && status.empty))
    else $error("Queue reports full and empty at once.");

  a_none_only_at_end: assert property (@(posedge clk) disable iff (rst)
    event_out.valid && event_out.event_kind == EV_NONE |-> event_out.end_of_text)
    else $error("Empty event emitted before the end of text.");

endmodule

### src/ispsc_front.sv
// Front end: accepts text beats and classifies each byte for the back end.
// Depends on ispsc_pkg and ispsc_text_if.
module ispsc_front (
  ispsc_text_if.sink             text_in,
  input  ispsc_pkg::queue_status_t status,
  output logic                   push,
  output ispsc_pkg::queue_entry_t entry
);
  import ispsc_pkg::*;

  assign text_in.ready = !status.full;
  assign push          = text_in.valid && !status.full;
  assign entry.cls     = classify(text_in.text_byte);
  assign entry.fin     = text_in.final_byte;

endmodule

### src/ispsc_queue.sv
// Short queue of classified bytes between the front and back ends.
// Depends on ispsc_pkg.
module ispsc_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  ispsc_pkg::queue_entry_t push_entry,
  input  logic                    pop,
  output ispsc_pkg::queue_entry_t head,
  output ispsc_pkg::queue_status_t status
);
  import ispsc_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  queue_entry_t        mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign head         = mem[rd_ptr];
  assign status.full  = (count == CNT_BITS'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

endmodule

### src/ispsc_back.sv
// Back end: runs the scan state machine on classified bytes and holds the
// event output register. Depends on ispsc_pkg and ispsc_event_if.
module ispsc_back #(
  parameter int OFFSET_BITS = ispsc_pkg::OFFSET_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ispsc_pkg::queue_entry_t head,
  input  ispsc_pkg::queue_status_t status,
  output logic                    pop,
  ispsc_event_if.source           event_out
);
  import ispsc_pkg::*;

  localparam int W = OFFSET_BITS;

  scan_mode_t  mode;
  scan_mode_t  mode_next;
  logic [W-1:0] pos;
  logic [W-1:0] token_start;
  logic [W-1:0] token_start_next;
  logic [W-1:0] key_len;
  logic [W-1:0] key_len_next;
  logic [W-1:0] value_begin;
  logic [W-1:0] value_begin_next;
  logic         prev_cr;

  event_kind_t  kind;
  logic [W-1:0] ns;
  logic [W-1:0] nl;
  logic [W-1:0] vs;
  logic [W-1:0] vl;
  logic         emit;
  byte_class_t  cls;
  logic         fin;

  function automatic logic [FIELD_BITS-1:0] fit_field(input logic [W-1:0] v);
    logic [31:0] e;
    e = 32'(v);
    return e[FIELD_BITS-1:0];
  endfunction

  assign cls = head.cls;
  assign fin = head.fin;
  assign pop = !status.empty && (!event_out.valid || event_out.ready);

  always_comb begin
    mode_next = mode;
    case (mode)
      MODE_PRE: begin
        if (cls inside {CLS_CR, CLS_LF}) mode_next = MODE_PRE;
        else if (cls == CLS_HASH) mode_next = MODE_PRE_CMT;
        else if (cls == CLS_LBRACK) mode_next = MODE_SEC;
        else mode_next = MODE_ERR;
      end
      MODE_PRE_CMT: if (cls == CLS_LF) mode_next = MODE_PRE;
      MODE_SEC: begin
        if (cls == CLS_RBRACK) mode_next = MODE_BODY;
        else if (cls == CLS_LF) mode_next = MODE_ERR;
      end
      MODE_BODY: begin
        if (cls inside {CLS_CR, CLS_LF}) mode_next = MODE_BODY;
        else if (cls == CLS_HASH) mode_next = MODE_BODY_CMT;
        else if (cls == CLS_LBRACK) mode_next = MODE_SEC;
        else mode_next = MODE_KEY;
      end
      MODE_BODY_CMT: if (cls == CLS_LF) mode_next = MODE_BODY;
      MODE_KEY: begin
        if (cls == CLS_LF) mode_next = MODE_ERR;
        else if (cls == CLS_EQ) mode_next = MODE_GAP;
      end
      MODE_GAP: begin
        if (cls == CLS_BLANK) mode_next = MODE_GAP;
        else if (cls == CLS_LF) mode_next = MODE_BODY;
        else mode_next = MODE_VAL;
      end
      MODE_VAL: if (cls == CLS_LF) mode_next = MODE_BODY;
      default: mode_next = MODE_ERR;
    endcase
  end

  always_comb begin
    kind             = EV_NONE;
    ns               = '0;
    nl               = '0;
    vs               = '0;
    vl               = '0;
    token_start_next = token_start;
    key_len_next     = key_len;
    value_begin_next = value_begin;
    case (mode)
      MODE_PRE: begin
        if (cls == CLS_LBRACK) token_start_next = pos + W'(1);
        else if (!(cls inside {CLS_CR, CLS_LF, CLS_HASH})) kind = EV_ERROR;
      end
      MODE_SEC: begin
        if (cls == CLS_RBRACK) begin
          kind = EV_SECTION;
          ns   = token_start;
          nl   = pos - token_start;
        end else if (cls == CLS_LF) begin
          kind = EV_ERROR;
        end
      end
      MODE_BODY: begin
        if (cls == CLS_LBRACK) begin
          token_start_next = pos + W'(1);
        end else if (!(cls inside {CLS_CR, CLS_LF, CLS_HASH})) begin
          token_start_next = pos;
          key_len_next     = W'(1);
        end
      end
      MODE_KEY: begin
        if (cls == CLS_LF) kind = EV_ERROR;
        else if (!(cls inside {CLS_EQ, CLS_BLANK})) key_len_next = pos - token_start + W'(1);
      end
      MODE_GAP: begin
        if (cls == CLS_LF) begin
          kind = EV_PAIR;
          ns   = token_start;
          nl   = key_len;
          vs   = pos;
        end else if (cls != CLS_BLANK) begin
          value_begin_next = pos;
        end
      end
      MODE_VAL: begin
        if (cls == CLS_LF) begin
          kind = EV_PAIR;
          ns   = token_start;
          nl   = key_len;
          vs   = value_begin;
          vl   = pos - value_begin - W'(prev_cr);
        end
      end
      default: kind = EV_NONE;
    endcase
    if (fin && kind == EV_NONE && mode_next != MODE_BODY && mode_next != MODE_BODY_CMT) begin
      kind = EV_ERROR;
    end
    emit = fin || (kind != EV_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_PRE;
      pos         <= '0;
      token_start <= '0;
      key_len     <= '0;
      value_begin <= '0;
      prev_cr     <= 1'b0;
    end else if (pop) begin
      if (fin) begin
        mode        <= MODE_PRE;
        pos         <= '0;
        token_start <= '0;
        key_len     <= '0;
        value_begin <= '0;
        prev_cr     <= 1'b0;
      end else begin
        mode        <= mode_next;
        pos         <= pos + W'(1);
        token_start <= token_start_next;
        key_len     <= key_len_next;
        value_begin <= value_begin_next;
        prev_cr     <= (cls == CLS_CR);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_out.valid <= 1'b0;
    end else if (pop) begin
      event_out.valid <= emit;
    end else if (event_out.ready) begin
      event_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      event_out.event_kind   <= kind;
      event_out.end_of_text  <= fin;
      event_out.name_start   <= fit_field(ns);
      event_out.name_length  <= fit_field(nl);
      event_out.value_start  <= fit_field(vs);
      event_out.value_length <= fit_field(vl);
    end
  end

endmodule

### test/tb_ini_section_pair_scanner.sv
// Self-checking testbench for ini_section_pair_scanner: feeds INI texts one byte per beat
// and checks every event beat against a built-in model of the scanner.
// Depends on ispsc_pkg, the channel interfaces in ispsc_if.sv and the scanner RTL.
module tb_ini_section_pair_scanner;
  import ispsc_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int RANDOM_BYTES = 1300;
  localparam int LONG_NAME_BYTES = 200;

  typedef struct packed {
    event_kind_t kind;
    logic        eot;
    logic [15:0] ns;
    logic [15:0] nl;
    logic [15:0] vs;
    logic [15:0] vl;
  } ini_event_t;

  class ini_event_board;
    scan_mode_t  mode;
    logic [15:0] pos;
    logic [15:0] tok_start;
    logic [15:0] key_len;
    logic [15:0] val_begin;
    logic        prev_cr;
    ini_event_t  expected_events[$];
    int          fail_count;

    function new();
      fail_count = 0;
      restart();
    endfunction

    function void restart();
      mode = MODE_PRE;
      pos = '0;
      tok_start = '0;
      key_len = '0;
      val_begin = '0;
      prev_cr = 1'b0;
    endfunction

    function int waiting();
      return expected_events.size();
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
      ini_event_t ev;
      logic lf, cr, blank;
      lf = (b == CHAR_LF);
      cr = (b == CHAR_CR);
      blank = (b == CHAR_SPACE) || (b == CHAR_TAB);
      ev = '0;
      ev.kind = EV_NONE;
      ev.eot = fin;
      case (mode)
        MODE_PRE: begin
          if (!(cr || lf)) begin
            if (b == CHAR_HASH) begin
              mode = MODE_PRE_CMT;
            end else if (b == CHAR_LBRACK) begin
              tok_start = pos + 16'd1;
              mode = MODE_SEC;
            end else begin
              ev.kind = EV_ERROR;
              mode = MODE_ERR;
            end
          end
        end
        MODE_PRE_CMT: begin
          if (lf) mode = MODE_PRE;
        end
        MODE_SEC: begin
          if (b == CHAR_RBRACK) begin
            ev.kind = EV_SECTION;
            ev.ns = tok_start;
            ev.nl = pos - tok_start;
            mode = MODE_BODY;
          end else if (lf) begin
            ev.kind = EV_ERROR;
            mode = MODE_ERR;
          end
        end
        MODE_BODY: begin
          if (!(cr || lf)) begin
            if (b == CHAR_HASH) begin
              mode = MODE_BODY_CMT;
            end else if (b == CHAR_LBRACK) begin
              tok_start = pos + 16'd1;
              mode = MODE_SEC;
            end else begin
              tok_start = pos;
              key_len = 16'd1;
              mode = MODE_KEY;
            end
          end
        end
        MODE_BODY_CMT: begin
          if (lf) mode = MODE_BODY;
        end
        MODE_KEY: begin
          if (lf) begin
            ev.kind = EV_ERROR;
            mode = MODE_ERR;
          end else if (b == CHAR_EQ) begin
            mode = MODE_GAP;
          end else if (!blank) begin
            key_len = pos - tok_start + 16'd1;
          end
        end
        MODE_GAP: begin
          if (!blank) begin
            if (lf) begin
              ev.kind = EV_PAIR;
              ev.ns = tok_start;
              ev.nl = key_len;
              ev.vs = pos;
              ev.vl = '0;
              mode = MODE_BODY;
            end else begin
              val_begin = pos;
              mode = MODE_VAL;
            end
          end
        end
        MODE_VAL: begin
          if (lf) begin
            ev.kind = EV_PAIR;
            ev.ns = tok_start;
            ev.nl = key_len;
            ev.vs = val_begin;
            ev.vl = pos - val_begin - {15'd0, prev_cr};
            mode = MODE_BODY;
          end
        end
        default: mode = MODE_ERR;
      endcase
      prev_cr = cr;
      pos = pos + 16'd1;
      if (fin) begin
        if (ev.kind == EV_NONE && mode != MODE_BODY && mode != MODE_BODY_CMT) begin
          ev.kind = EV_ERROR;
          ev.ns = '0;
          ev.nl = '0;
          ev.vs = '0;
          ev.vl = '0;
        end
        restart();
        expected_events.push_back(ev);
      end else if (ev.kind != EV_NONE) begin
        expected_events.push_back(ev);
      end
    endfunction

    function void compare_field(string field, logic [15:0] e, logic [15:0] a);
      if (a !== e) begin
        $error("%s mismatch: expected %0d, actual %0d", field, e, a);
        fail_count++;
      end
    endfunction

    function void check_event(ini_event_t got);
      ini_event_t exp;
      if (expected_events.size() == 0) begin
        $error("event beat with nothing expected: event_kind %0d", got.kind);
        fail_count++;
        return;
      end
      exp = expected_events.pop_front();
      compare_field("event_kind", {14'd0, exp.kind}, {14'd0, got.kind});
      compare_field("end_of_text", {15'd0, exp.eot}, {15'd0, got.eot});
      compare_field("name_start", exp.ns, got.ns);
      compare_field("name_length", exp.nl, got.nl);
      compare_field("value_start", exp.vs, got.vs);
      compare_field("value_length", exp.vl, got.vl);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit hold_off_req = 1'b0;
  int cycle_count = 0;
  logic [7:0] text_buf[$];
  ini_event_board board = new();

  ispsc_text_if text_ch();
  ispsc_event_if event_ch();

  ini_section_pair_scanner dut (
    .clk(clk),
    .rst(rst),
    .text_in(text_ch),
    .event_out(event_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, logic fin, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_ch.valid <= 1'b1;
    text_ch.text_byte <= b;
    text_ch.final_byte <= fin;
    do @(posedge clk); while (text_ch.ready !== 1'b1);
    board.note_byte(b, fin);
  endtask

  task automatic send_text(bit no_gap);
    foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1, no_gap);
    text_buf.delete();
  endtask

  task automatic drain_events();
    text_ch.valid <= 1'b0;
    do @(posedge clk); while (board.waiting() != 0);
  endtask

  task automatic receive_events();
    int gap;
    ini_event_t got;
    forever begin
      gap = $urandom_range(0, 7);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = 400;
      end
      if (gap > 0) begin
        event_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      event_ch.ready <= 1'b1;
      do @(posedge clk); while (event_ch.valid !== 1'b1);
      got.kind = event_kind_t'(event_ch.event_kind);
      got.eot = event_ch.end_of_text;
      got.ns = event_ch.name_start;
      got.nl = event_ch.name_length;
      got.vs = event_ch.value_start;
      got.vl = event_ch.value_length;
      board.check_event(got);
    end
  endtask

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_byte(logic [7:0] x0, logic [7:0] x1);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == x0 || b == x1);
    return b;
  endfunction

  function automatic logic [7:0] special_byte();
    logic [7:0] set[8];
    set = '{CHAR_CR, CHAR_LF, CHAR_HASH, CHAR_LBRACK, CHAR_RBRACK, CHAR_EQ, CHAR_SPACE,
            CHAR_TAB};
    return set[$urandom_range(0, 7)];
  endfunction

  function automatic void add_line_end();
    if ($urandom_range(0, 1)) text_buf.push_back(CHAR_CR);
    text_buf.push_back(CHAR_LF);
  endfunction

  function automatic void add_blanks(int n);
    repeat (n) text_buf.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
  endfunction

  function automatic void add_comment();
    text_buf.push_back(CHAR_HASH);
    repeat ($urandom_range(0, 4)) text_buf.push_back(pick_byte(CHAR_LF, CHAR_LF));
    text_buf.push_back(CHAR_LF);
  endfunction

  function automatic void add_pair();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CHAR_CR || b == CHAR_LF || b == CHAR_HASH || b == CHAR_LBRACK);
    text_buf.push_back(b);
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 3) == 0) add_blanks(1);
      else text_buf.push_back(pick_byte(CHAR_EQ, CHAR_LF));
    end
    add_blanks($urandom_range(0, 2));
    text_buf.push_back(CHAR_EQ);
    add_blanks($urandom_range(0, 2));
    repeat ($urandom_range(0, 6)) text_buf.push_back(pick_byte(CHAR_LF, CHAR_LF));
    add_line_end();
  endfunction

  function automatic void build_wellformed();
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 1)) add_comment();
      else add_line_end();
    end
    repeat ($urandom_range(1, 3)) begin
      text_buf.push_back(CHAR_LBRACK);
      repeat ($urandom_range(0, 4)) text_buf.push_back(pick_byte(CHAR_RBRACK, CHAR_LF));
      text_buf.push_back(CHAR_RBRACK);
      if ($urandom_range(0, 3) != 0) add_line_end();
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(0, 5))
          4: add_comment();
          5: add_line_end();
          default: add_pair();
        endcase
      end
    end
    if ($urandom_range(0, 3) == 0 && text_buf.size() > 4) begin
      repeat ($urandom_range(1, 3)) void'(text_buf.pop_back());
    end
  endfunction

  function automatic void build_noise();
    repeat ($urandom_range(1, 12)) begin
      text_buf.push_back($urandom_range(0, 1) ? special_byte() : 8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void build_broken();
    int idx;
    build_wellformed();
    idx = $urandom_range(0, text_buf.size() - 1);
    if ($urandom_range(0, 1)) text_buf[idx] = special_byte();
    else text_buf[idx] = 8'($urandom_range(0, 255));
  endfunction

  function automatic void build_long_text();
    text_buf.push_back(CHAR_LBRACK);
    repeat (LONG_NAME_BYTES) text_buf.push_back(pick_byte(CHAR_RBRACK, CHAR_LF));
    text_buf.push_back(CHAR_RBRACK);
    text_buf.push_back(CHAR_LF);
    add_str("keyname = wrapped value\r\n");
    add_pair();
    add_pair();
  endfunction

  initial begin
    int random_bytes;
    int text_count;
    rst <= 1'b1;
    text_ch.valid <= 1'b0;
    text_ch.text_byte <= '0;
    text_ch.final_byte <= 1'b0;
    event_ch.ready <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    fork
      receive_events();
    join_none

    text_buf.push_back(8'h00);
    text_buf.push_back(8'hFF);
    send_text(1'b0);
    add_str("#\n[]\n=\t=\n");
    send_text(1'b0);
    add_str("[s]k\n]x");
    send_text(1'b0);
    add_str("[s\n");
    send_text(1'b0);
    add_str("[]a=v\r\n");
    send_text(1'b0);

    random_bytes = 0;
    text_count = 0;
    while (random_bytes < RANDOM_BYTES) begin
      case ($urandom_range(0, 9))
        7: build_noise();
        8: build_broken();
        9: begin
          add_str("[x]\n");
          build_noise();
        end
        default: build_wellformed();
      endcase
      random_bytes += text_buf.size();
      text_count++;
      if (text_count == 6) hold_off_req = 1'b1;
      send_text(1'b0);
      if (text_count == 14) drain_events();
      if (text_count == 20) begin
        build_long_text();
        send_text(1'b1);
      end
    end

    drain_events();
    repeat (20) @(posedge clk);
    if (board.fail_count == 0 && board.waiting() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
